@@ hw/rtl/nge_pkg.sv @@
package nge_pkg;

	// Stack geometry and value width.
	localparam int STACK_DEPTH = 32;
	localparam int VALUE_WIDTH = 32;

	// Index into the stack memory, and a count that can also hold STACK_DEPTH.
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [IDX_W-1:0] stack_idx_t;
	typedef logic [CNT_W-1:0] stack_cnt_t;

	// Compare and push, load the new top after a pop, flush, load after a flush pop.
	typedef enum logic [1:0] {
		ST_CMP,
		ST_LOAD,
		ST_FLUSH,
		ST_FLOAD
	} back_state_t;

endpackage

@@ hw/rtl/nge_if.sv @@
// Input word channel: one sequence value and its end-of-sequence flag.
interface nge_item_if;
	import nge_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;
	logic   last_value;

	modport source(output valid, output value, output last_value, input ready);
	modport sink(input valid, input value, input last_value, output ready);
endinterface

// Result word channel: one reported element and its next greater element.
interface nge_result_if;
	import nge_pkg::*;

	logic   valid;
	logic   ready;
	value_t element;
	value_t greater;
	logic   found;
	logic   run_end;
	logic   overflow;

	modport source(output valid, output element, output greater, output found,
		output run_end, output overflow, input ready);
	modport sink(input valid, input element, input greater, input found,
		input run_end, input overflow, output ready);
endinterface

@@ hw/rtl/nge_front.sv @@
module nge_front (
	input logic       clk,
	input logic       arst_n,
	nge_item_if.sink   item,
	nge_item_if.source cmd
);
	import nge_pkg::*;

	// Two-entry queue so the input side keeps accepting while the stack engine works.
	value_t     value_q [2];
	logic       last_q  [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign item.ready = (fill_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign pop        = cmd.valid && cmd.ready;

	assign cmd.valid      = (fill_q != 2'd0);
	assign cmd.value      = value_q[rd_ptr_q];
	assign cmd.last_value = last_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			value_q[wr_ptr_q] <= item.value;
			last_q[wr_ptr_q]  <= item.last_value;
		end
	end

endmodule

@@ hw/rtl/nge_back.sv @@
module nge_back (
	input logic         clk,
	input logic         arst_n,
	nge_item_if.sink     cmd,
	nge_result_if.source result
);
	import nge_pkg::*;

	// Stack storage; the top entry is also kept in top_q for the compare.
	value_t      stack_mem [STACK_DEPTH];
	value_t      rd_q;
	value_t      top_q;
	stack_cnt_t  count_q;
	logic        ovf_q;
	back_state_t st_q;
	back_state_t st_d;

	// One result is held back until it is known whether it ends the word's run.
	logic   hold_valid_q;
	value_t hold_elem_q;
	value_t hold_grt_q;
	logic   hold_found_q;

	logic   out_valid_q;
	value_t out_elem_q;
	value_t out_grt_q;
	logic   out_found_q;
	logic   out_end_q;
	logic   out_ovf_q;

	logic       out_free;
	logic       go;
	logic       is_less;
	logic       do_pop;
	logic       do_push;
	logic       do_load;
	logic       set_ovf;
	logic       produce;
	logic       finish;
	logic       move;
	value_t     new_grt;
	logic       new_found;
	stack_cnt_t below_top;
	stack_idx_t rd_addr;

	assign out_free  = !out_valid_q || result.ready;
	assign go        = !hold_valid_q || out_free;
	assign is_less   = (top_q < cmd.value);
	assign below_top = count_q - stack_cnt_t'(2);
	assign rd_addr   = below_top[IDX_W-1:0];
	assign move      = (produce || finish) && hold_valid_q;
	assign cmd.ready = finish;

	always_comb begin
		st_d      = st_q;
		do_pop    = 1'b0;
		do_push   = 1'b0;
		do_load   = 1'b0;
		set_ovf   = 1'b0;
		produce   = 1'b0;
		finish    = 1'b0;
		new_grt   = cmd.value;
		new_found = 1'b1;
		unique case (st_q)
			ST_CMP: begin
				if (cmd.valid && go) begin
					if ((count_q != '0) && is_less) begin
						do_pop  = 1'b1;
						produce = 1'b1;
						st_d    = ST_LOAD;
					end else begin
						if (count_q < stack_cnt_t'(STACK_DEPTH)) begin
							do_push = 1'b1;
						end else begin
							set_ovf = 1'b1;
						end
						if (cmd.last_value) begin
							st_d = ST_FLUSH;
						end else begin
							finish = 1'b1;
						end
					end
				end
			end
			ST_LOAD: begin
				do_load = 1'b1;
				st_d    = ST_CMP;
			end
			ST_FLUSH: begin
				if (go) begin
					if (count_q != '0) begin
						do_pop    = 1'b1;
						produce   = 1'b1;
						new_grt   = '0;
						new_found = 1'b0;
						st_d      = ST_FLOAD;
					end else begin
						finish = 1'b1;
						st_d   = ST_CMP;
					end
				end
			end
			ST_FLOAD: begin
				do_load = 1'b1;
				st_d    = ST_FLUSH;
			end
			default: begin
				st_d = ST_CMP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CMP;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (do_pop) begin
				count_q <= count_q - stack_cnt_t'(1);
			end else if (do_push) begin
				count_q <= count_q + stack_cnt_t'(1);
			end
			if (set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (produce) begin
				hold_valid_q <= 1'b1;
			end else if (finish) begin
				hold_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= stack_mem[rd_addr];
		if (do_push) begin
			stack_mem[count_q[IDX_W-1:0]] <= cmd.value;
			top_q                         <= cmd.value;
		end else if (do_load) begin
			top_q <= rd_q;
		end
		if (produce) begin
			hold_elem_q  <= top_q;
			hold_grt_q   <= new_grt;
			hold_found_q <= new_found;
		end
		if (move) begin
			out_elem_q  <= hold_elem_q;
			out_grt_q   <= hold_grt_q;
			out_found_q <= hold_found_q;
			out_end_q   <= finish;
			out_ovf_q   <= ovf_q | set_ovf;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.element  = out_elem_q;
	assign result.greater  = out_grt_q;
	assign result.found    = out_found_q;
	assign result.run_end  = out_end_q;
	assign result.overflow = out_ovf_q;

endmodule

@@ hw/rtl/next_greater_element_stack.sv @@
// Next-greater-element engine on a monotonic stack.
// The item channel takes one signed value per word, with last_value set on the
// final value of a sequence. The result channel returns one word per reported
// element: the element, its next greater value and found, or found low when it
// had none. run_end marks the last result word caused by an input word, and
// overflow is the sticky flag that a value was dropped because the stack was full.
// A two-entry queue in the front accepts words while the stack engine works, so
// the input side only stalls once both queue entries are taken.
// Steps: a word that pops nothing and does not end a sequence needs only its
// compare step. Every pop adds a compare step and every flushed entry a flush
// step, each followed by a load step that takes the new top from the stack
// memory, whose read is registered. A word that ends a sequence adds a final
// flush step that finds the stack empty. Each result passes through the hold
// register and then the output register, since it is held until it is known
// whether it ends the run. Reset clears the stack count, the overflow flag,
// the queue and all valid flags; stack contents need no clearing.
// When the receiver stalls the output register holds its word and the engine
// stops, then the queue fills and the item channel drops ready.
module next_greater_element_stack (
	input logic         clk,
	input logic         arst_n,
	nge_item_if.sink     item,
	nge_result_if.source result
);
	import nge_pkg::*;

	// Words queued by the front and waiting for the stack engine.
	nge_item_if queue_ch ();

	nge_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (queue_ch.source)
	);

	// The back end owns the stack, the sticky overflow flag and the output register.
	nge_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (queue_ch.sink),
		.result (result)
	);

endmodule

@@ test/testbench.sv @@
typedef struct {
	nge_pkg::value_t element;
	nge_pkg::value_t greater;
	logic            found;
	logic            run_end;
	logic            overflow;
} nge_pair_t;

// Tracks the monotonic stack as the block should hold it, and the result words still owed.
class greater_pair_board;
	nge_pkg::value_t shadow_stack[nge_pkg::STACK_DEPTH];
	int              shadow_depth;
	logic            shadow_overflow;
	nge_pair_t       pending_pairs[$];
	int              mismatches;

	function new();
		shadow_depth = 0;
		shadow_overflow = 1'b0;
		mismatches = 0;
	endfunction

	// Works out every result word that one accepted input word causes.
	function void note_value(nge_pkg::value_t v, logic last);
		nge_pair_t batch[$];
		nge_pair_t p;
		p.run_end = 1'b0;
		p.overflow = 1'b0;
		while (shadow_depth > 0 && shadow_stack[shadow_depth-1] < v) begin
			shadow_depth--;
			p.element = shadow_stack[shadow_depth];
			p.greater = v;
			p.found = 1'b1;
			batch.push_back(p);
		end
		if (shadow_depth < nge_pkg::STACK_DEPTH) begin
			shadow_stack[shadow_depth] = v;
			shadow_depth++;
		end else begin
			shadow_overflow = 1'b1;
		end
		if (last) begin
			while (shadow_depth > 0) begin
				shadow_depth--;
				p.element = shadow_stack[shadow_depth];
				p.greater = '0;
				p.found = 1'b0;
				batch.push_back(p);
			end
		end
		foreach (batch[i]) begin
			batch[i].overflow = shadow_overflow;
			batch[i].run_end = (i == batch.size() - 1);
			pending_pairs.push_back(batch[i]);
		end
	endfunction

	function void compare_field(string field, nge_pkg::value_t want, nge_pkg::value_t got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $realtime, field, want, got);
			mismatches++;
		end
	endfunction

	function void check_pair(nge_pkg::value_t element, nge_pkg::value_t greater, logic found,
		logic run_end, logic overflow);
		nge_pair_t want;
		if (pending_pairs.size() == 0) begin
			$display("%0t: expected no word, got element %0d", $realtime, element);
			mismatches++;
			return;
		end
		want = pending_pairs.pop_front();
		compare_field("element", want.element, element);
		compare_field("greater", want.greater, greater);
		compare_field("found", nge_pkg::value_t'(want.found), nge_pkg::value_t'(found));
		compare_field("run_end", nge_pkg::value_t'(want.run_end), nge_pkg::value_t'(run_end));
		compare_field("overflow", nge_pkg::value_t'(want.overflow), nge_pkg::value_t'(overflow));
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nge_pkg::*;

	// The value extremes at the block's width.
	localparam value_t VMIN = value_t'({1'b1, {(VALUE_WIDTH-1){1'b0}}});
	localparam value_t VMAX = value_t'({1'b0, {(VALUE_WIDTH-1){1'b1}}});

	// How long the receiver refuses words in the back-pressure phase, in cycles.
	localparam int LONG_HOLD = 200;

	// Shapes of random sequences: fully random values, a narrow range that makes
	// equal neighbors common, falling and rising runs, and a mix of extremes.
	typedef enum int {
		SEQ_RANDOM,
		SEQ_NARROW,
		SEQ_FALLING,
		SEQ_RISING,
		SEQ_EXTREME
	} seq_kind_t;

	logic clk = 1'b0;
	logic arst_n;

	nge_item_if   item_ch();
	nge_result_if result_ch();

	next_greater_element_stack dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	greater_pair_board book = new();

	// Idling controls. The main process sets them per sequence; the receiver
	// process clears the hold request once its long stall has run out.
	logic tx_idle_on = 1'b0;
	logic rx_stalls_on = 1'b0;
	logic hold_request = 1'b0;
	int   words_sent = 0;
	int   stall_left = 0;

	always #2 clk = ~clk;

	// Every result word that crosses the handshake is checked against the oldest
	// expectation. Sampling in the active region at the rising edge sees the values
	// that were stable before the edge.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			book.check_pair(result_ch.element, result_ch.greater, result_ch.found,
				result_ch.run_end, result_ch.overflow);
	end

	// Receiver: ready changes only at the falling edge. It stalls in random bursts
	// while rx_stalls_on is set, and once, on hold_request, it refuses words until
	// the hold has run out, so that the stack engine stops, the front queue fills
	// and the item channel drops ready.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
				result_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one word from a falling edge and returns at the falling edge after it
	// was accepted. Valid is left high so the next word follows without a gap; the
	// expected results are worked out as soon as the word is taken.
	task automatic send_word(input value_t v, input logic last);
		item_ch.valid <= 1'b1;
		item_ch.value <= v;
		item_ch.last_value <= last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		book.note_value(v, last);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap(input int cycles);
		item_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Sends one whole sequence, last_value set on its final word, with random
	// gaps between words while sender idling is on.
	task automatic send_sequence(input seq_kind_t kind, input int len);
		value_t v;
		int     step;
		step = $urandom_range(0, 3);
		v = value_t'(int'($urandom_range(0, 2000)) - 1000);
		for (int i = 0; i < len; i++) begin
			case (kind)
				SEQ_RANDOM: v = value_t'($urandom);
				SEQ_NARROW: v = value_t'(int'($urandom_range(0, 8)) - 4);
				SEQ_FALLING: if (i > 0) v = v - value_t'(step);
				SEQ_RISING: if (i > 0) v = v + value_t'(step);
				default: begin
					case ($urandom_range(0, 4))
						0: v = VMIN;
						1: v = VMAX;
						2: v = '0;
						3: v = '1;
						default: v = value_t'($urandom);
					endcase
				end
			endcase
			send_word(v, i == len - 1);
			if (tx_idle_on && $urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 13));
		end
	endtask

	initial begin
		bit hold_done;
		hold_done = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.value = '0;
		item_ch.last_value = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, no idling on either side. A run through the extremes checks
		// the signed compare: -1 after 0 pops nothing, and 1 then pops both.
		send_word(VMIN, 1'b0);
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		send_word(value_t'(1), 1'b0);
		send_word(VMAX, 1'b1);
		// A mostly falling run: 0 pops -1, the other non-final words report nothing,
		// and the last word flushes the whole stack top-first with found low.
		send_word(VMAX, 1'b0);
		send_word(value_t'(1), 1'b0);
		send_word('1, 1'b0);
		send_word('0, 1'b0);
		send_word(VMIN, 1'b1);
		// Equal values stay on the stack until a strictly greater one arrives.
		send_word(value_t'(5), 1'b0);
		send_word(value_t'(5), 1'b0);
		send_word(value_t'(5), 1'b0);
		send_word(value_t'(6), 1'b1);
		// A sequence of one word.
		send_word(value_t'(7), 1'b1);
		// A mixed run with an equal pair in the middle.
		send_word(value_t'(-3), 1'b0);
		send_word(value_t'(2), 1'b0);
		send_word(value_t'(2), 1'b0);
		send_word(value_t'(-3), 1'b0);
		send_word(value_t'(9), 1'b1);

		// Random part. Sequences stay shorter than the stack, so no value is
		// dropped yet and the overflow flag stays low throughout.
		while (words_sent < 165) begin
			tx_idle_on = ($urandom_range(0, 2) != 0);
			rx_stalls_on = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 7) == 0)
				send_sequence(seq_kind_t'($urandom_range(0, 4)), $urandom_range(15, 30));
			else
				send_sequence(seq_kind_t'($urandom_range(0, 4)), $urandom_range(1, 10));

			// Halfway through, the receiver holds off for a long stretch while a
			// rising run keeps the sender busy, so the block backs up to its input.
			if (!hold_done && words_sent > 100) begin
				hold_done = 1'b1;
				tx_idle_on = 1'b0;
				rx_stalls_on = 1'b0;
				hold_request = 1'b1;
				send_sequence(SEQ_RISING, 14);
			end
		end

		// Last part, no idling. A falling run two words past the stack depth fills
		// the stack, drops the two extra words (the final one goes unreported) and
		// sets the sticky overflow flag.
		tx_idle_on = 1'b0;
		rx_stalls_on = 1'b0;
		for (int i = 0; i < STACK_DEPTH + 2; i++)
			send_word(value_t'(1000 - i), i == STACK_DEPTH + 1);
		// A full stack then meets the largest value as the final word: it pops all
		// entries and flushes itself, the most results a single word can cause.
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_word(value_t'(-i), 1'b0);
		send_word(VMAX, 1'b1);
		// The flag stays set across the following sequences.
		send_sequence(SEQ_RANDOM, 5);
		send_sequence(SEQ_NARROW, 6);
		item_ch.valid <= 1'b0;

		// Let every expected word arrive, then give the engine time to show any
		// stray word before the verdict.
		while (book.pending_pairs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (book.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// A hung handshake or a missing result word ends the run here.
	initial begin
		#4ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
